// ===== hdl/tsf_pkg.sv =====
package tsf_pkg;

  localparam int SAMPLE_W  = 13;
  localparam int SUM_W     = 17;
  localparam int WORD_W    = 16;
  localparam int SHIFT     = 3;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W    = 24;
  localparam int OFFSET_W  = 16;
  localparam int SCREEN_W  = 12;
  localparam int FRAC_W    = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNSTABLE = 2'd1,
    STATUS_WINDOW   = 2'd2
  } status_t;

  // Position of a run inside one reading: X, Y, X, Y.
  typedef enum logic [1:0] {
    RUN_X1 = 2'd0,
    RUN_Y1 = 2'd1,
    RUN_X2 = 2'd2,
    RUN_Y2 = 2'd3
  } run_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 3'd6;

  localparam logic [SAMPLE_W-1:0] DIFF_LIMIT_RESET = 13'd20;
  localparam logic [CFG_W-1:0]    WINDOW_RESET     = 26'd67100672;
  localparam logic [GAIN_W-1:0]   GAIN_RESET       = 24'd65536;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET     = 16'd0;

  typedef struct packed {
    logic [WORD_W-1:0] raw_word;
    logic              restart;
  } sample_in_t;

  typedef struct packed {
    status_t             status;
    sample_t             raw_x;
    sample_t             raw_y;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
  } result_t;

  // A finished run: its trimmed sum and its place in the reading.
  typedef struct packed {
    logic             valid;
    run_t             run;
    logic [SUM_W-1:0] trimmed;
  } run_tok_t;

  // A checked reading on its way to the screen mapping.
  typedef struct packed {
    logic    valid;
    status_t status;
    sample_t raw_x;
    sample_t raw_y;
  } check_tok_t;

endpackage

// ===== hdl/touch_sample_filter_calibrate.sv =====
// Touch sample filter and calibration. Each accepted request carries one raw
// converter word; the 13-bit sample is bits 15..3. Samples form four runs of
// SAMPLES each (X, Y, X, Y), and each run is reduced to a trimmed mean: the
// run's sum less its largest and smallest sample, divided by SAMPLES-2. After
// the last sample of the fourth run one result request is produced. If either
// axis's two means differ by more than diff_limit the status is unstable and
// raw_x/raw_y carry the differences. Otherwise the averaged means are checked
// against the raw windows (status outside window on a miss), and inside them
// each axis maps to screen = raw * gain (Q8.16) + offset, clamped to
// 0..SCREEN_*_MAX. Screen values are 0 whenever the status is not ok. A sample
// with restart set drops the partial reading and starts a new X run.
// Rate: one sample is accepted every clock cycle while sample_stall is low.
// The datapath is five register stages deep (accumulator, reciprocal multiply,
// stability and window check, gain multiply, clamp into the result register).
// sample_stall rises only when a result is held by result_stall and every stage
// behind it is full. Configuration is written through cfg_we/cfg_index/cfg_data
// while no reading is in flight; the user must keep to this, as the block does
// not enforce it. Indexes past the last register are ignored.
module touch_sample_filter_calibrate #(
  parameter int SAMPLES      = 5,
  parameter int SCREEN_X_MAX = 239,
  parameter int SCREEN_Y_MAX = 319
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  tsf_pkg::sample_in_t            sample,
  output logic                           result_valid,
  input  logic                           result_stall,
  output tsf_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsf_pkg::CFG_W-1:0]      cfg_data
);
  import tsf_pkg::*;

  // Configuration registers.
  logic [SAMPLE_W-1:0]        diff_limit;
  logic [CFG_W-1:0]           raw_x_window;
  logic [CFG_W-1:0]           raw_y_window;
  logic signed [GAIN_W-1:0]   x_gain;
  logic signed [OFFSET_W-1:0] x_offset;
  logic signed [GAIN_W-1:0]   y_gain;
  logic signed [OFFSET_W-1:0] y_offset;

  // Tokens passed between the stages, each with its own valid bit.
  run_tok_t   run_tok;
  logic       run_ready;
  check_tok_t check_tok;
  logic       check_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_limit   <= DIFF_LIMIT_RESET;
      raw_x_window <= WINDOW_RESET;
      raw_y_window <= WINDOW_RESET;
      x_gain       <= GAIN_RESET;
      x_offset     <= OFFSET_RESET;
      y_gain       <= GAIN_RESET;
      y_offset     <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIFF_LIMIT:   diff_limit   <= cfg_data[SAMPLE_W-1:0];
        CFG_RAW_X_WINDOW: raw_x_window <= cfg_data;
        CFG_RAW_Y_WINDOW: raw_y_window <= cfg_data;
        CFG_X_GAIN:       x_gain       <= cfg_data[GAIN_W-1:0];
        CFG_X_OFFSET:     x_offset     <= cfg_data[OFFSET_W-1:0];
        CFG_Y_GAIN:       y_gain       <= cfg_data[GAIN_W-1:0];
        CFG_Y_OFFSET:     y_offset     <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Running sum, maximum and minimum of the current run; emits the trimmed
  // sum when a run closes.
  tsf_accum #(
    .SAMPLES(SAMPLES)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .run_ready   (run_ready),
    .run_tok     (run_tok)
  );

  // Divides by the trimmed count, keeps the four means, and checks the
  // completed reading for stability and against the raw windows.
  tsf_mean #(
    .SAMPLES(SAMPLES)
  ) u_mean (
    .clk         (clk),
    .rst         (rst),
    .run_tok     (run_tok),
    .run_ready   (run_ready),
    .diff_limit  (diff_limit),
    .raw_x_window(raw_x_window),
    .raw_y_window(raw_y_window),
    .check_ready (check_ready),
    .check_tok   (check_tok)
  );

  // Gain and offset, then the clamp into the result register.
  tsf_scale #(
    .SCREEN_X_MAX(SCREEN_X_MAX),
    .SCREEN_Y_MAX(SCREEN_Y_MAX)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .check_tok   (check_tok),
    .check_ready (check_ready),
    .x_gain      (x_gain),
    .x_offset    (x_offset),
    .y_gain      (y_gain),
    .y_offset    (y_offset),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

// ===== hdl/tsf_accum.sv =====
module tsf_accum #(
  parameter int SAMPLES = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  tsf_pkg::sample_in_t sample,
  input  logic                run_ready,
  output tsf_pkg::run_tok_t   run_tok
);
  import tsf_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

  logic [CNT_W-1:0] sample_index;
  logic [CNT_W-1:0] index_eff;
  run_t             run;
  run_t             run_eff;
  logic [SUM_W-1:0] run_sum;
  logic [SUM_W-1:0] sum_eff;
  logic [SUM_W-1:0] sum_next;
  sample_t          run_max;
  sample_t          run_min;
  sample_t          max_eff;
  sample_t          min_eff;
  sample_t          max_next;
  sample_t          min_next;
  sample_t          v;
  logic             tok_free;
  logic             accept;
  logic             last;

  assign v            = sample.raw_word[WORD_W-1:SHIFT];
  assign tok_free     = !run_tok.valid || run_ready;
  assign sample_stall = !tok_free;
  assign accept       = sample_valid && tok_free;

  // A restart drops the partial reading before this sample is counted.
  always_comb begin
    if (sample.restart) begin
      index_eff = '0;
      run_eff   = RUN_X1;
      sum_eff   = '0;
      max_eff   = '0;
      min_eff   = '1;
    end else begin
      index_eff = sample_index;
      run_eff   = run;
      sum_eff   = run_sum;
      max_eff   = run_max;
      min_eff   = run_min;
    end
    sum_next = sum_eff + SUM_W'(v);
    max_next = (v > max_eff) ? v : max_eff;
    min_next = (v < min_eff) ? v : min_eff;
    last     = (index_eff == LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      run           <= RUN_X1;
      run_sum       <= '0;
      run_max       <= '0;
      run_min       <= '1;
      run_tok.valid <= 1'b0;
    end else begin
      if (tok_free) begin
        run_tok.valid <= accept && last;
      end
      if (accept) begin
        if (last) begin
          sample_index    <= '0;
          run             <= run_t'(2'(run_eff) + 2'd1);
          run_sum         <= '0;
          run_max         <= '0;
          run_min         <= '1;
          run_tok.run     <= run_eff;
          run_tok.trimmed <= sum_next - SUM_W'(max_next) - SUM_W'(min_next);
        end else begin
          sample_index <= index_eff + CNT_W'(1);
          run          <= run_eff;
          run_sum      <= sum_next;
          run_max      <= max_next;
          run_min      <= min_next;
        end
      end
    end
  end

endmodule

// ===== hdl/tsf_mean.sv =====
module tsf_mean #(
  parameter int SAMPLES = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tsf_pkg::run_tok_t         run_tok,
  output logic                      run_ready,
  input  logic [tsf_pkg::SAMPLE_W-1:0] diff_limit,
  input  logic [tsf_pkg::CFG_W-1:0] raw_x_window,
  input  logic [tsf_pkg::CFG_W-1:0] raw_y_window,
  input  logic                      check_ready,
  output tsf_pkg::check_tok_t       check_tok
);
  import tsf_pkg::*;

  // Exact division by the trimmed count through a rounded-up reciprocal.
  localparam int DIV    = SAMPLES - 2;
  localparam int SH     = SUM_W + $clog2(DIV);
  localparam int RW     = SH + 1;
  localparam int PROD_W = SUM_W + RW;
  localparam logic [RW-1:0] RECIP = RW'(((1 << SH) + DIV - 1) / DIV);

  logic [PROD_W-1:0] prod;
  sample_t           mean;
  sample_t           first_x_mean;
  sample_t           first_y_mean;
  sample_t           second_x_mean;
  sample_t           second_y_mean;
  logic              y_valid;
  logic              s3_free;
  logic              s2_free;
  logic              take;
  sample_t           dx;
  sample_t           dy;
  logic [SAMPLE_W:0] sum_x;
  logic [SAMPLE_W:0] sum_y;
  sample_t           ax;
  sample_t           ay;
  logic              unstable;
  logic              outside;

  assign prod = PROD_W'(run_tok.trimmed) * PROD_W'(RECIP);
  assign mean = prod[SH +: SAMPLE_W];

  assign s3_free   = !check_tok.valid || check_ready;
  assign s2_free   = !y_valid || s3_free;
  assign run_ready = s2_free;
  assign take      = run_tok.valid && s2_free;

  always_comb begin
    dx = (first_x_mean >= second_x_mean) ? first_x_mean - second_x_mean
                                         : second_x_mean - first_x_mean;
    dy = (first_y_mean >= second_y_mean) ? first_y_mean - second_y_mean
                                         : second_y_mean - first_y_mean;
    sum_x    = {1'b0, first_x_mean} + {1'b0, second_x_mean};
    sum_y    = {1'b0, first_y_mean} + {1'b0, second_y_mean};
    ax       = sum_x[SAMPLE_W:1];
    ay       = sum_y[SAMPLE_W:1];
    unstable = (dx > diff_limit) || (dy > diff_limit);
    outside  = (ax > raw_x_window[2*SAMPLE_W-1:SAMPLE_W]) ||
               (ax < raw_x_window[SAMPLE_W-1:0]) ||
               (ay > raw_y_window[2*SAMPLE_W-1:SAMPLE_W]) ||
               (ay < raw_y_window[SAMPLE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid         <= 1'b0;
      check_tok.valid <= 1'b0;
      first_x_mean    <= '0;
      first_y_mean    <= '0;
      second_x_mean   <= '0;
    end else begin
      if (s3_free) begin
        check_tok.valid <= y_valid;
      end
      if (y_valid && s3_free) begin
        if (unstable) begin
          check_tok.status <= STATUS_UNSTABLE;
          check_tok.raw_x  <= dx;
          check_tok.raw_y  <= dy;
        end else begin
          check_tok.status <= outside ? STATUS_WINDOW : STATUS_OK;
          check_tok.raw_x  <= ax;
          check_tok.raw_y  <= ay;
        end
      end
      if (s2_free) begin
        y_valid <= take && (run_tok.run == RUN_Y2);
      end
      if (take) begin
        case (run_tok.run)
          RUN_X1:  first_x_mean  <= mean;
          RUN_Y1:  first_y_mean  <= mean;
          RUN_X2:  second_x_mean <= mean;
          RUN_Y2:  second_y_mean <= mean;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/tsf_scale.sv =====
module tsf_scale #(
  parameter int SCREEN_X_MAX = 239,
  parameter int SCREEN_Y_MAX = 319
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tsf_pkg::check_tok_t                 check_tok,
  output logic                                check_ready,
  input  logic signed [tsf_pkg::GAIN_W-1:0]   x_gain,
  input  logic signed [tsf_pkg::OFFSET_W-1:0] x_offset,
  input  logic signed [tsf_pkg::GAIN_W-1:0]   y_gain,
  input  logic signed [tsf_pkg::OFFSET_W-1:0] y_offset,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tsf_pkg::result_t                    result
);
  import tsf_pkg::*;

  localparam int PROD_W  = SAMPLE_W + 1 + GAIN_W;
  localparam int VAL_W   = PROD_W + 1;
  localparam int WHOLE_W = VAL_W - 1 - FRAC_W;
  localparam logic [SCREEN_W-1:0] X_MAX = SCREEN_W'(SCREEN_X_MAX);
  localparam logic [SCREEN_W-1:0] Y_MAX = SCREEN_W'(SCREEN_Y_MAX);

  logic                     scaled_valid;
  status_t                  scaled_status;
  sample_t                  scaled_raw_x;
  sample_t                  scaled_raw_y;
  logic signed [VAL_W-1:0]  scaled_x;
  logic signed [VAL_W-1:0]  scaled_y;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [VAL_W-1:0]  val_x;
  logic signed [VAL_W-1:0]  val_y;
  logic                     out_free;

  function automatic logic [SCREEN_W-1:0] clamp_screen(logic signed [VAL_W-1:0] v,
                                                       logic [SCREEN_W-1:0] maxv);
    logic [WHOLE_W-1:0] whole;
    whole = v[VAL_W-2:FRAC_W];
    if (v[VAL_W-1]) begin
      return '0;
    end else if (whole > WHOLE_W'(maxv)) begin
      return maxv;
    end else begin
      return whole[SCREEN_W-1:0];
    end
  endfunction

  assign out_free    = !result_valid || !result_stall;
  assign check_ready = !scaled_valid || out_free;

  // Raw value times Q8.16 gain, plus the offset moved up to the same scale.
  always_comb begin
    prod_x = $signed({1'b0, check_tok.raw_x}) * x_gain;
    prod_y = $signed({1'b0, check_tok.raw_y}) * y_gain;
    val_x  = {prod_x[PROD_W-1], prod_x} +
             {{(VAL_W-OFFSET_W-FRAC_W){x_offset[OFFSET_W-1]}}, x_offset, FRAC_W'(0)};
    val_y  = {prod_y[PROD_W-1], prod_y} +
             {{(VAL_W-OFFSET_W-FRAC_W){y_offset[OFFSET_W-1]}}, y_offset, FRAC_W'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (check_ready) begin
        scaled_valid <= check_tok.valid;
      end
      if (check_ready && check_tok.valid) begin
        scaled_status <= check_tok.status;
        scaled_raw_x  <= check_tok.raw_x;
        scaled_raw_y  <= check_tok.raw_y;
        scaled_x      <= val_x;
        scaled_y      <= val_y;
      end
      if (out_free) begin
        result_valid <= scaled_valid;
      end
      if (out_free && scaled_valid) begin
        result.status <= scaled_status;
        result.raw_x  <= scaled_raw_x;
        result.raw_y  <= scaled_raw_y;
        if (scaled_status == STATUS_OK) begin
          result.screen_x <= clamp_screen(scaled_x, X_MAX);
          result.screen_y <= clamp_screen(scaled_y, Y_MAX);
        end else begin
          result.screen_x <= '0;
          result.screen_y <= '0;
        end
      end
    end
  end

endmodule

// ===== hdl/tsf_checker.sv =====
module tsf_checker #(
  parameter int SCREEN_X_MAX = 239,
  parameter int SCREEN_Y_MAX = 319
) (
  input logic             clk,
  input logic             rst,
  input logic             sample_stall,
  input logic             result_valid,
  input logic             result_stall,
  input tsf_pkg::result_t result
);
  import tsf_pkg::*;

  // A held result keeps its value until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(result_valid && result_stall)) |->
      (result_valid && $stable(result)))
    else $error("result changed while stalled");

  // Reset empties every stage, so nothing is shown and samples flow at once.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !sample_stall))
    else $error("pipeline not empty after reset");

  // Screen coordinates are only given for a good reading.
  a_screen_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != STATUS_OK) |->
      (result.screen_x == '0 && result.screen_y == '0))
    else $error("screen value on a failed reading");

  // A good reading lands on the screen.
  a_screen_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_OK) |->
      (result.screen_x <= SCREEN_X_MAX && result.screen_y <= SCREEN_Y_MAX))
    else $error("screen value outside the screen");

endmodule

bind touch_sample_filter_calibrate tsf_checker #(
  .SCREEN_X_MAX(SCREEN_X_MAX),
  .SCREEN_Y_MAX(SCREEN_Y_MAX)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for touch_sample_filter_calibrate.
//
// A small tracker class follows the block's filter state: the position inside
// the X, Y, X, Y reading, the running sum, maximum and minimum of the current
// run, and the three trimmed means that are held until the fourth run ends.
// Every accepted sample request goes into the tracker. When a sample closes
// the fourth run, the tracker queues the expected result. Every accepted
// result request is then checked field by field against the oldest entry in
// that queue.
//
// The stimulus opens with a few hand-picked readings. They cover all-zero and
// all-ones words, an unstable X and an unstable Y, a partial reading dropped
// by restart, a trimmed outlier, an empty raw window, and screen values that
// clamp at zero and at the panel maximum. Random phases follow, each under
// its own register setting, extremes included. Most random traffic is whole
// readings with noisy content. The rest is stray samples and readings that
// are cut off and restarted.
module testbench;
  import tsf_pkg::*;

  localparam int SAMPLES      = 5;
  localparam int SCREEN_X_MAX = 239;
  localparam int SCREEN_Y_MAX = 319;
  // Sample to result delay through the datapath.
  localparam int LATENCY      = 5;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 560;
  localparam int MAX_REPORTS  = 10;
  // No register sits at this index; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Follows the filter state and holds the readings that are still expected.
  class reading_tracker;
    logic [SAMPLE_W-1:0]        limit_diff;
    logic [CFG_W-1:0]           win_x;
    logic [CFG_W-1:0]           win_y;
    logic signed [GAIN_W-1:0]   gain_x;
    logic signed [GAIN_W-1:0]   gain_y;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;

    int unsigned      count_in_reading;
    logic [SUM_W-1:0] acc_sum;
    sample_t          acc_max;
    sample_t          acc_min;
    sample_t          x_mean_a;
    sample_t          y_mean_a;
    sample_t          x_mean_b;

    result_t pending_readings[$];
    int      samples_seen;
    int      readings_checked;
    int      fail_count;
    int      status_count[3];

    function new();
      limit_diff       = DIFF_LIMIT_RESET;
      win_x            = WINDOW_RESET;
      win_y            = WINDOW_RESET;
      gain_x           = GAIN_RESET;
      gain_y           = GAIN_RESET;
      offset_x         = OFFSET_RESET;
      offset_y         = OFFSET_RESET;
      count_in_reading = 0;
      x_mean_a         = '0;
      y_mean_a         = '0;
      x_mean_b         = '0;
      samples_seen     = 0;
      readings_checked = 0;
      fail_count       = 0;
      status_count     = '{0, 0, 0};
      clear_run();
    endfunction

    function void clear_run();
      acc_sum = '0;
      acc_max = '0;
      acc_min = '1;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        CFG_DIFF_LIMIT:   limit_diff = data[SAMPLE_W-1:0];
        CFG_RAW_X_WINDOW: win_x = data;
        CFG_RAW_Y_WINDOW: win_y = data;
        CFG_X_GAIN:       gain_x = data[GAIN_W-1:0];
        CFG_X_OFFSET:     offset_x = data[OFFSET_W-1:0];
        CFG_Y_GAIN:       gain_y = data[GAIN_W-1:0];
        CFG_Y_OFFSET:     offset_y = data[OFFSET_W-1:0];
        default: ;
      endcase
    endfunction

    // Q8.16 scale plus offset; the fraction is dropped and the value clamped.
    function logic [SCREEN_W-1:0] map_axis(sample_t raw, logic signed [GAIN_W-1:0] gain,
                                           logic signed [OFFSET_W-1:0] offset, int max_v);
      longint scaled;
      scaled = longint'(raw) * longint'(gain) + (longint'(offset) <<< FRAC_W);
      if (scaled < 0) begin
        return '0;
      end
      scaled = scaled >>> FRAC_W;
      if (scaled > max_v) begin
        return SCREEN_W'(max_v);
      end
      return SCREEN_W'(scaled);
    endfunction

    function void accept_sample(sample_in_t s);
      sample_t     v;
      logic [31:0] trimmed;
      sample_t     mean;
      sample_t     dx;
      sample_t     dy;
      sample_t     ax;
      sample_t     ay;
      int unsigned run_no;
      result_t     exp_r;
      v = s.raw_word[WORD_W-1:SHIFT];
      samples_seen++;
      if (s.restart) begin
        count_in_reading = 0;
        clear_run();
      end
      if (count_in_reading >= 4 * SAMPLES) begin
        count_in_reading = 0;
      end
      acc_sum = acc_sum + SUM_W'(v);
      if (v > acc_max) begin
        acc_max = v;
      end
      if (v < acc_min) begin
        acc_min = v;
      end
      count_in_reading++;
      if (count_in_reading % SAMPLES != 0) begin
        return;
      end
      trimmed = 32'(acc_sum) - 32'(acc_max) - 32'(acc_min);
      mean = sample_t'(trimmed / (SAMPLES - 2));
      run_no = count_in_reading / SAMPLES;
      clear_run();
      if (run_no == 1) begin
        x_mean_a = mean;
        return;
      end
      if (run_no == 2) begin
        y_mean_a = mean;
        return;
      end
      if (run_no == 3) begin
        x_mean_b = mean;
        return;
      end
      count_in_reading = 0;
      dx = (x_mean_a > x_mean_b) ? x_mean_a - x_mean_b : x_mean_b - x_mean_a;
      dy = (y_mean_a > mean) ? y_mean_a - mean : mean - y_mean_a;
      exp_r = '0;
      if (dx > limit_diff || dy > limit_diff) begin
        exp_r.status = STATUS_UNSTABLE;
        exp_r.raw_x  = dx;
        exp_r.raw_y  = dy;
      end else begin
        ax = sample_t'((14'(x_mean_a) + 14'(x_mean_b)) >> 1);
        ay = sample_t'((14'(y_mean_a) + 14'(mean)) >> 1);
        exp_r.raw_x = ax;
        exp_r.raw_y = ay;
        if (ax > win_x[CFG_W-1:SAMPLE_W] || ax < win_x[SAMPLE_W-1:0] ||
            ay > win_y[CFG_W-1:SAMPLE_W] || ay < win_y[SAMPLE_W-1:0]) begin
          exp_r.status = STATUS_WINDOW;
        end else begin
          exp_r.status   = STATUS_OK;
          exp_r.screen_x = map_axis(ax, gain_x, offset_x, SCREEN_X_MAX);
          exp_r.screen_y = map_axis(ay, gain_y, offset_y, SCREEN_Y_MAX);
        end
      end
      status_count[exp_r.status]++;
      pending_readings.push_back(exp_r);
    endfunction

    function void report(string what, result_t exp_r, result_t got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("ERROR %s: expected status %0d x %0d y %0d sx %0d sy %0d",
                 what, exp_r.status, exp_r.raw_x, exp_r.raw_y, exp_r.screen_x,
                 exp_r.screen_y);
        $display("      got status %0d x %0d y %0d sx %0d sy %0d", got.status,
                 got.raw_x, got.raw_y, got.screen_x, got.screen_y);
      end
    endfunction

    function void check_reading(result_t got);
      result_t exp_r;
      if (pending_readings.size() == 0) begin
        report("result with nothing expected", '0, got);
        return;
      end
      exp_r = pending_readings.pop_front();
      readings_checked++;
      if (got.status !== exp_r.status || got.raw_x !== exp_r.raw_x ||
          got.raw_y !== exp_r.raw_y || got.screen_x !== exp_r.screen_x ||
          got.screen_y !== exp_r.screen_y) begin
        report("result mismatch", exp_r, got);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 sample_valid;
  logic                 sample_stall;
  sample_in_t           sample;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  reading_tracker board;
  // The sender and receiver idle in random gaps only while these are set.
  bit gaps_on      = 1'b1;
  bit stall_on     = 1'b1;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_pending = 1'b0;
  int settings_count = 0;
  int cycle_count    = 0;

  touch_sample_filter_calibrate #(
    .SAMPLES      (SAMPLES),
    .SCREEN_X_MAX (SCREEN_X_MAX),
    .SCREEN_Y_MAX (SCREEN_Y_MAX)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // The watchdog. A correct run ends far below this count, even with every
  // result held for its longest stall.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               board.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Both monitors run right after the rising edge. At that point every signal
  // still holds the value that the block saw at the edge, so a handshake is
  // counted exactly when the block counts it.
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      board.accept_sample(sample);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      board.check_reading(result);
    end
  end

  // The receiver. It holds off in short random bursts while stall_on is set.
  // On request it also stalls once for a long stretch. That stretch is long
  // enough for the pipeline to fill and push back on the sample input.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Offers one sample request and returns at the edge that accepts it. The
  // valid is either lowered for a gap or left high, never both in one step.
  task automatic send_sample(sample_in_t s);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Builds a converter word for a 13-bit level. The three bits below the
  // sample are random noise, except at the two extremes, where the words are
  // exactly all zeros and all ones.
  function automatic sample_in_t make_sample(int level, bit restart_bit);
    sample_in_t s;
    int         v;
    v = (level < 0) ? 0 : (level > 8191) ? 8191 : level;
    s.raw_word[WORD_W-1:SHIFT] = sample_t'(v);
    s.raw_word[SHIFT-1:0]      = (v == 0) ? 3'b000 : (v == 8191) ? 3'b111 : 3'($urandom);
    s.restart = restart_bit;
    return s;
  endfunction

  task automatic send_run(int base, int spread, bit outliers, bit restart_first);
    for (int i = 0; i < SAMPLES; i++) begin
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (outliers && $urandom_range(0, 7) == 0) begin
        v = $urandom_range(0, 8191);
      end
      send_sample(make_sample(v, restart_first && i == 0));
    end
  endtask

  // One reading, X Y X Y. The second X and Y runs sit dx and dy away from the
  // first ones.
  task automatic send_reading(int bx, int by, int dx, int dy, int spread, bit outliers,
                              bit restart_first);
    send_run(bx, spread, outliers, restart_first);
    send_run(by, spread, outliers, 1'b0);
    send_run(bx + dx, spread, outliers, 1'b0);
    send_run(by + dy, spread, outliers, 1'b0);
  endtask

  // Stray samples. About one in four carries restart.
  task automatic send_scraps(int count);
    for (int i = 0; i < count; i++) begin
      send_sample(make_sample($urandom_range(0, 8191), $urandom_range(0, 3) == 0));
    end
  endtask

  function automatic int pick_level();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 8);
      1:       return $urandom_range(8183, 8191);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // Most readings are steady. About one in four moves far between its runs.
  function automatic int pick_delta();
    if ($urandom_range(0, 3) == 0) begin
      return int'($urandom_range(0, 8191)) - 4096;
    end
    return int'($urandom_range(0, 40)) - 20;
  endfunction

  task automatic random_reading(bit force_restart);
    send_reading(pick_level(), pick_level(), pick_delta(), pick_delta(),
                 $urandom_range(0, 6), 1'b1, force_restart | 1'($urandom_range(0, 1)));
  endtask

  // Drops the sample valid and waits until every expected result has been
  // checked. The first edge lets the monitor take in the last accepted
  // sample. It then waits out the pipeline, because a sample that closes no
  // reading can still be in flight inside the block.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  // Starts one register write. The write enable stays high, so the writes of
  // one setting go out back to back.
  task automatic write_one(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    board.set_register(index, data);
  endtask

  // Writes every register, plus one write to the unused index with random
  // data that the block must drop.
  task automatic program_registers(logic [SAMPLE_W-1:0] diff, logic [CFG_W-1:0] xw,
                                   logic [CFG_W-1:0] yw, logic [GAIN_W-1:0] xg,
                                   logic [OFFSET_W-1:0] xo, logic [GAIN_W-1:0] yg,
                                   logic [OFFSET_W-1:0] yo);
    write_one(CFG_DIFF_LIMIT, CFG_W'(diff));
    write_one(CFG_RAW_X_WINDOW, xw);
    write_one(CFG_RAW_Y_WINDOW, yw);
    write_one(CFG_X_GAIN, CFG_W'(xg));
    write_one(CFG_X_OFFSET, CFG_W'(xo));
    write_one(CFG_Y_GAIN, CFG_W'(yg));
    write_one(CFG_Y_OFFSET, CFG_W'(yo));
    write_one(CFG_UNUSED, CFG_W'($urandom));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [CFG_W-1:0] random_window();
    if ($urandom_range(0, 4) == 0) begin
      return CFG_W'($urandom);
    end
    return {13'($urandom_range(4096, 8191)), 13'($urandom_range(0, 4095))};
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    if ($urandom_range(0, 3) == 0) begin
      return GAIN_W'($urandom);
    end
    return GAIN_W'(int'($urandom_range(0, 3 * 65536)) - 65536);
  endfunction

  initial begin
    int random_start;
    int phase_start;
    int choice;
    board        = new();
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed readings at unity gain and full windows. They cover the
    // extreme words, two unstable readings (X alone, then Y alone), a
    // partial reading that a restart drops, and a run with outliers.
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    program_registers(DIFF_LIMIT_RESET, WINDOW_RESET, WINDOW_RESET, GAIN_RESET,
                      OFFSET_RESET, GAIN_RESET, OFFSET_RESET);
    send_reading(0, 0, 0, 0, 0, 1'b0, 1'b1);
    send_reading(8191, 8191, 0, 0, 0, 1'b0, 1'b0);
    send_reading(100, 150, 0, 0, 0, 1'b0, 1'b0);
    send_reading(100, 200, 2900, 10, 0, 1'b0, 1'b0);
    send_reading(500, 4000, 5, 100, 0, 1'b0, 1'b0);
    send_scraps(7);
    send_reading(1000, 1500, 10, -10, 0, 1'b0, 1'b1);
    send_reading(2000, 2000, 0, 0, 3, 1'b1, 1'b0);

    // Zero difference allowed, and an empty X window: its minimum lies above
    // its maximum, so the reading must fall outside it.
    wait_drained();
    program_registers(13'd0, {13'd200, 13'd300}, WINDOW_RESET, 24'hFF0000, 16'h7FFF,
                      GAIN_RESET, 16'h8000);
    send_reading(250, 250, 0, 0, 0, 1'b0, 1'b1);

    // Largest difference limit, most negative X offset and most negative Y
    // gain. Both screen values clamp at zero. Then a zero reading sends Y to
    // the panel maximum through the positive offset.
    wait_drained();
    program_registers(13'h1FFF, WINDOW_RESET, WINDOW_RESET, GAIN_RESET, 16'h8000,
                      24'h800000, 16'h7FFF);
    send_reading(10, 3000, 7990, 0, 0, 1'b0, 1'b1);
    send_reading(0, 0, 0, 0, 0, 1'b0, 1'b1);

    // Random phases, each under its own setting. Phase 2 also asks for the
    // long result hold-off; it runs longer and never waits for the block to drain,
    // so the pipeline fills while the receiver holds off. Phase 3 runs with no
    // idling at all, and so does the last phase.
    random_start = board.samples_seen;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: program_registers(DIFF_LIMIT_RESET, WINDOW_RESET, WINDOW_RESET, GAIN_RESET,
                             OFFSET_RESET, GAIN_RESET, OFFSET_RESET);
        1: program_registers(13'h1FFF, WINDOW_RESET, WINDOW_RESET, 24'h7FFFFF, 16'h7FFF,
                             24'h7FFFFF, 16'h7FFF);
        2: program_registers(13'd0, 26'h0, 26'h3FFFFFF, 24'h800000, 16'h8000,
                             24'h800000, 16'h8000);
        default: program_registers(($urandom_range(0, 1) != 0) ? 13'($urandom) :
                                   13'($urandom_range(0, 40)), random_window(),
                                   random_window(), random_gain(), 16'($urandom),
                                   random_gain(), 16'($urandom));
      endcase
      gaps_on  = (phase != 3 && phase != 5);
      stall_on = (phase != 3 && phase != 5);
      if (phase == 2) begin
        hold_pending = 1'b1;
      end
      phase_start = board.samples_seen;
      while (board.samples_seen - phase_start < ((phase == 2) ? 200 : 70) ||
             (phase == 5 && board.samples_seen - random_start < RANDOM_ITEMS)) begin
        choice = $urandom_range(0, 19);
        if (choice < 15) begin
          random_reading(1'b0);
        end else if (choice < 17) begin
          send_scraps($urandom_range(1, 12));
        end else if (choice < 19) begin
          // A reading cut off somewhere inside, then a restarted one.
          send_scraps($urandom_range(1, 4 * SAMPLES - 1));
          random_reading(1'b1);
        end else if (phase != 2) begin
          wait_drained();
        end
      end
    end
    wait_drained();

    $display("Run covered %0d samples and %0d readings: %0d ok, %0d unstable, %0d outside window.",
             board.samples_seen, board.readings_checked, board.status_count[STATUS_OK],
             board.status_count[STATUS_UNSTABLE], board.status_count[STATUS_WINDOW]);
    $display("%0d register settings, random idling, one long result hold-off; %0d mismatches.",
             settings_count, board.fail_count);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
